FILE: hdl/lla_pkg.sv
package lla_pkg;

  // Command codes carried in the input tuser field.
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_STEP  = 2'd2
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_BIRTH   = 2'd0,
    REG_SURVIVE = 2'd1,
    REG_ROWS    = 2'd2,
    REG_COLS    = 2'd3
  } reg_idx_t;

  typedef logic [8:0] rule_mask_t;

  // Register values after reset: B3/S23 on a full-size field.
  localparam rule_mask_t RESET_BIRTH   = 9'b000001000;
  localparam rule_mask_t RESET_SURVIVE = 9'b000001100;
  localparam logic [8:0] RESET_SIZE    = 9'd256;

  // One column of the 3x3 neighbourhood window.
  typedef struct packed {
    logic dn;
    logic mid;
    logic up;
  } column_t;

  typedef struct packed {
    column_t right;
    column_t centre;
    column_t left;
  } window_t;

  // A stored cell: the current value, and the value it held before the
  // generation sweep that last wrote it.
  typedef struct packed {
    logic prior;
    logic now;
  } cell_word_t;

endpackage

FILE: hdl/lla_field_ram.sv
module lla_field_ram import lla_pkg::*; #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  cell_word_t    wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output cell_word_t    rdata_a,
  output cell_word_t    rdata_b
);

  cell_word_t mem [DEPTH];

  // One write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: hdl/lla_rule_unit.sv
module lla_rule_unit import lla_pkg::*; (
  input  window_t    win,
  input  rule_mask_t birth_mask,
  input  rule_mask_t survive_mask,
  output logic       cell_next
);

  logic [3:0] count;

  // Live neighbours: the eight cells around the centre.
  assign count = 4'(win.left.up) + 4'(win.left.mid) + 4'(win.left.dn)
               + 4'(win.centre.up) + 4'(win.centre.dn)
               + 4'(win.right.up) + 4'(win.right.mid) + 4'(win.right.dn);

  // A live centre looks up the survive mask, a dead one the birth mask.
  always_comb begin
    if (win.centre.mid) begin
      cell_next = survive_mask[count];
    end else begin
      cell_next = birth_mask[count];
    end
  end

endmodule

FILE: hdl/life_like_automaton_torus_step.sv
// Life-like cellular automaton on a torus, one command per input transaction.
// Input channel s_*: tuser carries the command (write cell, read cell, advance
// one generation), tdata the row, column and value to write. Every command
// gives exactly one output transaction on m_*: tdata carries the cell read,
// tuser the error flag for a coordinate outside the size in use or an unused
// command. Configuration (rule masks, field size) is written on cfg_*; the
// user must write it only while the block is idle, which the block itself
// does not enforce. A write or an error goes from idle straight to the
// result state, a read through one registered field memory read. For a
// generation the sequencer fetches one column of three cells per pass
// through FETCH_A, FETCH_B and FETCH_C over the two read ports of the field
// memory and updates one cell per column; each row needs two extra fetches
// to fill the wrap-around window. One command is in flight at a time and
// s_tready is low until its result has moved into the output register.
// After reset a clearing pass writes every one of MAX_ROWS * MAX_COLS cells
// dead, one per cycle, with s_tready low; configuration writes are taken.
// When the receiver stalls, the result waits in the output register; the next
// command is still taken and worked through, and its result is held until
// that slot is free.
module life_like_automaton_torus_step import lla_pkg::*; #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // row [7:0], col [15:8], cell_in [16], zero pad
  input  logic [1:0]  s_tuser,   // cmd [1:0]
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // cell_out [0], zero pad
  output logic        m_tuser,   // status [0]
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam logic [8:0] ROWS_CAP = (MAX_ROWS > 511) ? 9'd511 : 9'(MAX_ROWS);
  localparam logic [8:0] COLS_CAP = (MAX_COLS > 511) ? 9'd511 : 9'(MAX_COLS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FETCH_A,
    ST_FETCH_B,
    ST_FETCH_C,
    ST_RESULT
  } state_t;

  typedef enum logic [1:0] {
    FETCH_LEFT,
    FETCH_FIRST,
    FETCH_RIGHT
  } phase_t;

  state_t         state;
  phase_t         phase;
  logic [AW-1:0]  clr_cnt;
  logic [RW-1:0]  gi;
  logic [CW-1:0]  gj;
  logic [CW-1:0]  fc;
  logic           flag_up;
  logic           flag_mid;
  logic           flag_dn;
  logic           tmp_up;
  logic           tmp_mid;
  column_t        col_m;
  column_t        col_r;
  logic           res_cell;
  logic           res_status;
  logic           cell_out;
  logic           status;

  rule_mask_t     birth_mask;
  rule_mask_t     survive_mask;
  logic [8:0]     rows_in_use;
  logic [8:0]     cols_in_use;

  logic [8:0]     eff_rows;
  logic [8:0]     eff_cols;
  logic [8:0]     last_r9;
  logic [8:0]     last_c9;
  logic [RW-1:0]  last_r;
  logic [CW-1:0]  last_c;

  logic [7:0]     in_row;
  logic [7:0]     in_col;
  logic           in_cell;
  logic           in_range;
  logic [AW-1:0]  cmd_addr;

  logic [RW-1:0]  up_row;
  logic [RW-1:0]  dn_row;
  logic [CW-1:0]  j_next;
  logic [CW-1:0]  rt_of_next;
  logic [CW-1:0]  first_rt;
  logic           dn_bit;
  column_t        new_col;
  window_t        win_eval;
  logic           cell_next;

  logic           we;
  logic [AW-1:0]  waddr;
  cell_word_t     wdata;
  logic [AW-1:0]  raddr_a;
  logic [AW-1:0]  raddr_b;
  cell_word_t     rdata_a;
  cell_word_t     rdata_b;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                              input logic [CW-1:0] c);
    cell_addr = AW'(r * MAX_COLS + c);
  endfunction

  // A cell has already been rewritten in this sweep when it lies in an
  // earlier row, or earlier in the row being updated.
  function automatic logic swept(input logic [RW-1:0] r, input logic [CW-1:0] c,
                                 input logic [RW-1:0] cur_r,
                                 input logic [CW-1:0] cur_c);
    swept = (r < cur_r) || ((r == cur_r) && (c < cur_c));
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      birth_mask   <= RESET_BIRTH;
      survive_mask <= RESET_SURVIVE;
      rows_in_use  <= RESET_SIZE;
      cols_in_use  <= RESET_SIZE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BIRTH:   birth_mask   <= cfg_data;
        REG_SURVIVE: survive_mask <= cfg_data;
        REG_ROWS:    rows_in_use  <= cfg_data;
        REG_COLS:    cols_in_use  <= cfg_data;
        default:     ;
      endcase
    end
  end

  // Field size in use, with zero taken as one and large values capped.
  always_comb begin
    if (rows_in_use == 9'd0) begin
      eff_rows = 9'd1;
    end else if (rows_in_use > ROWS_CAP) begin
      eff_rows = ROWS_CAP;
    end else begin
      eff_rows = rows_in_use;
    end
    if (cols_in_use == 9'd0) begin
      eff_cols = 9'd1;
    end else if (cols_in_use > COLS_CAP) begin
      eff_cols = COLS_CAP;
    end else begin
      eff_cols = cols_in_use;
    end
  end

  assign last_r9 = eff_rows - 9'd1;
  assign last_c9 = eff_cols - 9'd1;
  assign last_r  = RW'(last_r9);
  assign last_c  = CW'(last_c9);

  // Command fields and the coordinate check.
  assign in_row   = s_tdata[7:0];
  assign in_col   = s_tdata[15:8];
  assign in_cell  = s_tdata[16];
  assign in_range = ({1'b0, in_row} <= last_r9) && ({1'b0, in_col} <= last_c9);
  assign cmd_addr = cell_addr(RW'(in_row), CW'(in_col));

  // Wrapped neighbour rows and the next column to fetch.
  assign up_row     = (gi == '0) ? last_r : gi - RW'(1);
  assign dn_row     = (gi == last_r) ? '0 : gi + RW'(1);
  assign j_next     = gj + CW'(1);
  assign rt_of_next = (j_next == last_c) ? '0 : j_next + CW'(1);
  assign first_rt   = (last_c == '0) ? '0 : CW'(1);

  // The column arriving from memory, and the window it completes.
  assign dn_bit      = flag_dn ? rdata_a.prior : rdata_a.now;
  assign new_col.up  = tmp_up;
  assign new_col.mid = tmp_mid;
  assign new_col.dn  = dn_bit;
  assign win_eval.left   = col_m;
  assign win_eval.centre = col_r;
  assign win_eval.right  = new_col;

  lla_rule_unit u_rule (
    .win          (win_eval),
    .birth_mask   (birth_mask),
    .survive_mask (survive_mask),
    .cell_next    (cell_next)
  );

  // Read addresses: command reads in idle, the three cells of a column
  // in FETCH_A and FETCH_B during a generation.
  always_comb begin
    unique case (state)
      ST_FETCH_A: raddr_a = cell_addr(up_row, fc);
      ST_FETCH_B: raddr_a = cell_addr(dn_row, fc);
      default:    raddr_a = cmd_addr;
    endcase
    raddr_b = cell_addr(gi, fc);
  end

  // Write port: clearing pass, cell writes and generation updates.
  always_comb begin
    we          = 1'b0;
    waddr       = cmd_addr;
    wdata.prior = in_cell;
    wdata.now   = in_cell;
    unique case (state)
      ST_CLEAR: begin
        we          = 1'b1;
        waddr       = clr_cnt;
        wdata.prior = 1'b0;
        wdata.now   = 1'b0;
      end
      ST_IDLE: begin
        we = s_tvalid && (s_tuser == CMD_WRITE) && in_range;
      end
      ST_FETCH_C: begin
        we          = (phase == FETCH_RIGHT);
        waddr       = cell_addr(gi, gj);
        wdata.prior = col_r.mid;
        wdata.now   = cell_next;
      end
      default: ;
    endcase
  end

  lla_field_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // The result state refills the output register itself when it drains.
      if (m_tvalid && m_tready && (state != ST_RESULT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (clr_cnt == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr_cnt <= clr_cnt + AW'(1);
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            unique case (s_tuser)
              CMD_WRITE: begin
                res_cell   <= 1'b0;
                res_status <= !in_range;
                state      <= ST_RESULT;
              end
              CMD_READ: begin
                res_cell   <= 1'b0;
                res_status <= !in_range;
                if (in_range) begin
                  state <= ST_READ;
                end else begin
                  state <= ST_RESULT;
                end
              end
              CMD_STEP: begin
                res_cell   <= 1'b0;
                res_status <= 1'b0;
                gi         <= '0;
                gj         <= '0;
                fc         <= last_c;
                phase      <= FETCH_LEFT;
                state      <= ST_FETCH_A;
              end
              default: begin
                res_cell   <= 1'b0;
                res_status <= 1'b1;
                state      <= ST_RESULT;
              end
            endcase
          end
        end
        ST_READ: begin
          res_cell <= rdata_a.now;
          state    <= ST_RESULT;
        end
        ST_FETCH_A: begin
          flag_up  <= swept(up_row, fc, gi, gj);
          flag_mid <= swept(gi, fc, gi, gj);
          state    <= ST_FETCH_B;
        end
        ST_FETCH_B: begin
          flag_dn <= swept(dn_row, fc, gi, gj);
          tmp_up  <= flag_up ? rdata_a.prior : rdata_a.now;
          tmp_mid <= flag_mid ? rdata_b.prior : rdata_b.now;
          state   <= ST_FETCH_C;
        end
        ST_FETCH_C: begin
          col_m <= col_r;
          col_r <= new_col;
          unique case (phase)
            FETCH_LEFT: begin
              fc    <= '0;
              phase <= FETCH_FIRST;
              state <= ST_FETCH_A;
            end
            FETCH_FIRST: begin
              fc    <= first_rt;
              phase <= FETCH_RIGHT;
              state <= ST_FETCH_A;
            end
            FETCH_RIGHT: begin
              if (gj == last_c) begin
                if (gi == last_r) begin
                  state <= ST_RESULT;
                end else begin
                  gi    <= gi + RW'(1);
                  gj    <= '0;
                  fc    <= last_c;
                  phase <= FETCH_LEFT;
                  state <= ST_FETCH_A;
                end
              end else begin
                gj    <= j_next;
                fc    <= rt_of_next;
                state <= ST_FETCH_A;
              end
            end
            default: begin
              state <= ST_RESULT;
            end
          endcase
        end
        ST_RESULT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            cell_out <= res_cell;
            status   <= res_status;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {7'd0, cell_out};
  assign m_tuser  = status;

endmodule
